@@ hw/rtl/ipv4dq_pkg.sv @@
package ipv4dq_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned OCTET_W  = 10;
  localparam int unsigned DIGITS_W = 3;
  localparam int unsigned PERIOD_W = 2;

  localparam logic [CHAR_W-1:0]   PERIOD_CHAR = 8'h2E;
  localparam logic [CHAR_W-1:0]   ZERO_CHAR   = 8'h30;
  localparam logic [CHAR_W-1:0]   NINE_CHAR   = 8'h39;
  localparam logic [OCTET_W-1:0]  OCTET_MAX   = 10'd255;
  localparam logic [DIGITS_W-1:0] DIGITS_MAX  = 3'd3;
  localparam logic [PERIOD_W-1:0] PERIODS_MAX = 2'd3;

endpackage

@@ hw/rtl/ipv4_dotted_quad_checker.sv @@
// the result of a character is registered and appears in the cycle after its transfer
// throughput: one character per cycle while the result side is not stalled
// the single result register holds a stalled result; input stalls then and in reset
// synchronous active-high rst clears the octet state and empties the result
module ipv4_dotted_quad_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [ipv4dq_pkg::CHAR_W-1:0] character,
  input  logic                         start_req,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         valid_res
);
  import ipv4dq_pkg::*;

  logic [OCTET_W-1:0]  octet_value, octet_value_next;
  logic [DIGITS_W-1:0] digit_count, digit_count_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic                rejected, rejected_next;
  logic                ok_next;
  logic                accept;
  logic [OCTET_W-1:0]  octet_sum;

  assign char_stall = rst || (res_valid && res_stall);
  assign accept     = char_valid && !char_stall;

  always_comb begin
    octet_value_next  = start_req ? '0 : octet_value;
    digit_count_next  = start_req ? '0 : digit_count;
    period_count_next = start_req ? '0 : period_count;
    rejected_next     = start_req ? 1'b0 : rejected;
    octet_sum = (octet_value_next << 3) + (octet_value_next << 1)
              + {2'b00, character - ZERO_CHAR};
    if (!rejected_next) begin
      if (character inside {[ZERO_CHAR:NINE_CHAR]}) begin
        if (digit_count_next >= DIGITS_MAX) begin
          rejected_next = 1'b1;
        end else begin
          octet_value_next = octet_sum;
          digit_count_next = digit_count_next + 3'd1;
          if (octet_sum > OCTET_MAX) begin
            rejected_next = 1'b1;
          end
        end
      end else if (character == PERIOD_CHAR) begin
        if (digit_count_next == '0 || period_count_next >= PERIODS_MAX ||
            (period_count_next == '0 && octet_value_next == '0)) begin
          rejected_next = 1'b1;
        end else begin
          period_count_next = period_count_next + 2'd1;
          octet_value_next  = '0;
          digit_count_next  = '0;
        end
      end else begin
        rejected_next = 1'b1;
      end
    end
    ok_next = !rejected_next && period_count_next == PERIODS_MAX &&
              digit_count_next != '0 && digit_count_next <= DIGITS_MAX &&
              octet_value_next != '0 && octet_value_next <= OCTET_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octet_value  <= '0;
      digit_count  <= '0;
      period_count <= '0;
      rejected     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        octet_value  <= octet_value_next;
        digit_count  <= digit_count_next;
        period_count <= period_count_next;
        rejected     <= rejected_next;
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      valid_res <= ok_next;
    end
  end

endmodule

@@ hw/rtl/ipv4dq_checker.sv @@
module ipv4dq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          char_valid,
  input logic                          char_stall,
  input logic [ipv4dq_pkg::CHAR_W-1:0] character,
  input logic                          start_req,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic                          valid_res
);
  import ipv4dq_pkg::*;

  // outside reset, input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> res_valid && res_stall)
    else $error("input stalled without a held result");

  // every input transfer yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall |=> res_valid)
    else $error("no result after input transfer");

  // held result keeps its value
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(valid_res))
    else $error("stalled result changed");

  // a foreign character can never leave a valid address
  a_foreign_char: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && character != PERIOD_CHAR &&
    (character < ZERO_CHAR || character > NINE_CHAR) |=> !valid_res)
    else $error("valid result after foreign character");

  // a lone first character is never a full address
  a_start_short: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && start_req |=> !valid_res)
    else $error("valid result after one character");

endmodule

bind ipv4_dotted_quad_checker ipv4dq_checker u_ipv4dq_checker (
  .clk        (clk),
  .rst        (rst),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .character  (character),
  .start_req  (start_req),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .valid_res  (valid_res)
);
